/* src/jlae_pkg.sv */
// jlae_pkg: shared types, codes and constants for the joint limit aggregator
// with expiry. Used by jlae_alu, jlae_store and the top level.
// No dependencies.
package jlae_pkg;

   // default parameter values
   localparam int MAX_JOINTS_DEF = 8;
   localparam int VALUE_BITS_DEF = 32;

   // fixed sizes
   localparam int NUM_KINDS    = 5;
   localparam int NUM_DEFAULTS = 4;
   localparam int STAMP_BITS   = 32;

   // configuration register indexes and reset values
   localparam int CSR_INDEX_BITS = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_JOINT_COUNT   = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STALE_TIMEOUT = 4'd1;
   localparam logic [3:0]                JOINT_COUNT_RST   = 4'd1;
   localparam logic [31:0]               STALE_TIMEOUT_RST = 32'd100000;

   // operation codes
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_UPDATE = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   // limit kinds, in present_mask bit order
   typedef enum logic [2:0] {
      KIND_POS_UPPER = 3'd0,
      KIND_POS_LOWER = 3'd1,
      KIND_VEL_UPPER = 3'd2,
      KIND_VEL_LOWER = 3'd3,
      KIND_EFFORT    = 3'd4
   } kind_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_UPD_RD,
      ST_UPD_EX,
      ST_TCK_RD,
      ST_TCK_EX,
      ST_TCK_OUT
   } state_type;

   // write controls toward the limit store
   typedef struct packed {
      logic hld_we;
      logic stp_we;
      logic dfl_we;
      logic vld_set;
   } store_ctl_type;

   // mode controls toward the compare unit
   typedef struct packed {
      logic tick;
      logic upper;
      logic negate;
   } alu_ctl_type;

   // upper kinds and effort tighten downward
   function automatic logic is_upper(kind_type k);
      is_upper = (k == KIND_POS_UPPER) || (k == KIND_VEL_UPPER) || (k == KIND_EFFORT);
   endfunction

   // default slot of a kind; velocity lower shares the magnitude slot
   function automatic logic [1:0] dfl_slot(kind_type k);
      logic [1:0] s;
      case (k)
         KIND_POS_UPPER: s = 2'd0;
         KIND_POS_LOWER: s = 2'd1;
         KIND_VEL_UPPER: s = 2'd2;
         KIND_VEL_LOWER: s = 2'd2;
         default:        s = 2'd3;
      endcase
      dfl_slot = s;
   endfunction

endpackage

/* src/jlae_alu.sv */
// jlae_alu: shared compare unit, one limit kind per use: tightening compare,
// default derivation and stamp recency check.
// Depends on jlae_pkg.
module jlae_alu #(
   parameter int VALUE_BITS = jlae_pkg::VALUE_BITS_DEF
) (
   input  jlae_pkg::alu_ctl_type  ctl,
   input  logic [VALUE_BITS-1:0]  cand,
   input  logic [VALUE_BITS-1:0]  held,
   input  logic [VALUE_BITS-1:0]  dfl_raw,
   input  logic [31:0]            now,
   input  logic [31:0]            stamp,
   input  logic [31:0]            timeout,
   output logic [VALUE_BITS-1:0]  dflt,
   output logic                   tighter,
   output logic [VALUE_BITS-1:0]  eff,
   output logic                   recent
);

   localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   logic [VALUE_BITS-1:0] op_a;
   logic [VALUE_BITS-1:0] op_b;
   logic [32:0]           fwd_diff;
   logic [31:0]           abs_diff;

   // default, negated with saturation for velocity lower
   always_comb begin
      if (!ctl.negate) begin
         dflt = dfl_raw;
      end else if (dfl_raw == VMIN) begin
         dflt = VMAX;
      end else begin
         dflt = VALUE_BITS'(-$signed(dfl_raw));
      end
   end

   // one signed compare: is op_a more restrictive than op_b
   assign op_a = ctl.tick ? held : cand;
   assign op_b = ctl.tick ? dflt : held;

   always_comb begin
      if (ctl.upper) begin
         tighter = $signed(op_a) < $signed(op_b);
      end else begin
         tighter = $signed(op_b) < $signed(op_a);
      end
   end

   // plain absolute stamp difference against the timeout
   assign fwd_diff = {1'b0, now} - {1'b0, stamp};
   assign abs_diff = fwd_diff[32] ? (stamp - now) : fwd_diff[31:0];
   assign recent   = abs_diff <= timeout;

   // reported value: tighter of held and default while recent
   assign eff = (recent && tighter) ? held : dflt;

endmodule

/* src/jlae_store.sv */
// jlae_store: default, held and stamp memories with registered reads, plus
// per-joint valid bits so stamps of unloaded joints read as zero.
// Depends on jlae_pkg.
module jlae_store #(
   parameter int MAX_JOINTS = jlae_pkg::MAX_JOINTS_DEF,
   parameter int VALUE_BITS = jlae_pkg::VALUE_BITS_DEF,
   localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  jlae_pkg::store_ctl_type  ctl,
   input  logic [JW-1:0]            joint,
   input  jlae_pkg::kind_type       kind,
   input  logic [VALUE_BITS-1:0]    hld_wdata,
   input  logic [31:0]              stp_wdata,
   input  logic [VALUE_BITS-1:0]    dfl_wdata,
   output logic [VALUE_BITS-1:0]    hld_rdata,
   output logic [31:0]              stp_rdata,
   output logic [VALUE_BITS-1:0]    dfl_rdata
);

   localparam int HDEPTH = jlae_pkg::NUM_KINDS * MAX_JOINTS;
   localparam int DDEPTH = jlae_pkg::NUM_DEFAULTS * MAX_JOINTS;
   localparam int HAW    = $clog2(HDEPTH);
   localparam int DAW    = JW + 2;

   logic [VALUE_BITS-1:0] hld_mem [HDEPTH];
   logic [31:0]           stp_mem [HDEPTH];
   logic [VALUE_BITS-1:0] dfl_mem [DDEPTH];

   logic [HAW-1:0]        haddr;
   logic [DAW-1:0]        daddr;
   logic [MAX_JOINTS-1:0] vld_ff;
   logic [MAX_JOINTS-1:0] vld_in;
   logic                  vld_rd_ff;
   logic [VALUE_BITS-1:0] hld_rd_ff;
   logic [31:0]           stp_rd_ff;
   logic [VALUE_BITS-1:0] dfl_rd_ff;

   // entry addresses: five held entries and four defaults per joint
   assign haddr = HAW'({joint, 2'b00}) + HAW'(joint) + HAW'(kind);
   assign daddr = {joint, jlae_pkg::dfl_slot(kind)};

   // joint valid bits, set by a load
   always_comb begin
      vld_in = vld_ff;
      if (ctl.vld_set) begin
         vld_in[joint] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (ctl.hld_we) begin
         hld_mem[haddr] <= hld_wdata;
      end
      if (ctl.stp_we) begin
         stp_mem[haddr] <= stp_wdata;
      end
      if (ctl.dfl_we) begin
         dfl_mem[daddr] <= dfl_wdata;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      hld_rd_ff <= hld_mem[haddr];
      stp_rd_ff <= stp_mem[haddr];
      dfl_rd_ff <= dfl_mem[daddr];
      vld_rd_ff <= vld_ff[joint];
   end

   assign hld_rdata = hld_rd_ff;
   assign dfl_rdata = dfl_rd_ff;
   assign stp_rdata = vld_rd_ff ? stp_rd_ff : '0;

endmodule

/* src/joint_limit_aggregator_with_expiry_unit.sv */
// joint_limit_aggregator_with_expiry_unit: top level with the sequencer,
// item capture, configuration registers and result register.
// Depends on jlae_pkg, jlae_alu and jlae_store.
//
//   channel   direction  handshake             carries
//   req_*     in         req_valid/req_ready   one load, update or tick item
//   rsp_*     out        rsp_valid/rsp_ready   one joint's effective limits
//   csr_*     in         csr_we                joint_count, stale_timeout
//
// A load starts from the idle state that takes the beat and writes each kind in
// turn in ST_LOAD; an update reads then compares each kind in ST_UPD_RD and
// ST_UPD_EX, through the one compare unit and the single read port. A tick reads and
// compares each kind in ST_TCK_RD and ST_TCK_EX for each joint in use, then waits in
// ST_TCK_OUT on rsp_ready while the result register is full; with no joints in use it stays idle.
// req_ready is high only while the sequencer idles; the last result of a tick
// may still wait in the result register then. No clearing pass after reset.
module joint_limit_aggregator_with_expiry_unit #(
   parameter int MAX_JOINTS = jlae_pkg::MAX_JOINTS_DEF,
   parameter int VALUE_BITS = jlae_pkg::VALUE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic [2:0]                           req_joint,
   input  logic [31:0]                          req_time_now,
   input  logic signed [31:0]                   req_pos_upper,
   input  logic signed [31:0]                   req_pos_lower,
   input  logic signed [31:0]                   req_vel_upper,
   input  logic signed [31:0]                   req_vel_lower,
   input  logic signed [31:0]                   req_effort,
   input  logic [4:0]                           req_present_mask,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_out_joint,
   output logic signed [31:0]                   rsp_out_pos_upper,
   output logic signed [31:0]                   rsp_out_pos_lower,
   output logic signed [31:0]                   rsp_out_vel_upper,
   output logic signed [31:0]                   rsp_out_vel_lower,
   output logic signed [31:0]                   rsp_out_effort,
   output logic [31:0]                          rsp_out_stamp,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [jlae_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [31:0]                          csr_wdata
);

   localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int CW = $clog2(MAX_JOINTS + 1);
   localparam int NK = jlae_pkg::NUM_KINDS;

   jlae_pkg::state_type     state_ff, state_in;
   jlae_pkg::kind_type      kind_ff, kind_in;
   jlae_pkg::kind_type      rsel;
   logic [JW-1:0]           joint_ff, joint_in;
   logic [31:0]             time_ff, time_in;
   logic [VALUE_BITS-1:0]   val_ff [NK];
   logic [VALUE_BITS-1:0]   val_in [NK];
   logic [4:0]              mask_ff, mask_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           num_ff, num_in;
   logic [CW-1:0]           num_req;
   logic [VALUE_BITS-1:0]   res_ff [NK];
   logic [VALUE_BITS-1:0]   res_in [NK];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              oj_ff, oj_in;
   logic [31:0]             ov_ff [NK];
   logic [31:0]             ov_in [NK];
   logic [31:0]             ostamp_ff, ostamp_in;
   logic                    olast_ff, olast_in;
   logic [3:0]              jcount_ff, jcount_in;
   logic [31:0]             timeout_ff, timeout_in;

   logic                    accept;
   logic                    joint_ok;
   logic                    kind_last;
   logic                    joint_last;
   logic                    out_free;
   logic                    out_load;
   logic [VALUE_BITS-1:0]   val_sel;

   jlae_pkg::store_ctl_type st_ctl;
   jlae_pkg::alu_ctl_type   alu_ctl;
   logic [VALUE_BITS-1:0]   hld_wdata, hld_rdata, dfl_rdata, alu_dfl_raw;
   logic [31:0]             stp_wdata, stp_rdata;
   logic [VALUE_BITS-1:0]   alu_dflt, alu_eff;
   logic                    alu_tighter, alu_recent;

   // handshake and sequencing conditions
   assign accept     = req_valid && req_ready;
   assign joint_ok   = int'(req_joint) < MAX_JOINTS;
   assign num_req    = (int'(jcount_ff) > MAX_JOINTS) ? CW'(MAX_JOINTS) : CW'(jcount_ff);
   assign kind_last  = kind_ff == jlae_pkg::KIND_EFFORT;
   assign joint_last = CW'(cnt_ff + 1'b1) == num_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign out_load   = (state_ff == jlae_pkg::ST_TCK_OUT) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jlae_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  jlae_pkg::OP_LOAD: begin
                     if (joint_ok) state_in = jlae_pkg::ST_LOAD;
                  end
                  jlae_pkg::OP_UPDATE: begin
                     if (joint_ok) state_in = jlae_pkg::ST_UPD_RD;
                  end
                  jlae_pkg::OP_TICK: begin
                     if (num_req != '0) state_in = jlae_pkg::ST_TCK_RD;
                  end
                  default: state_in = jlae_pkg::ST_IDLE;
               endcase
            end
         end
         jlae_pkg::ST_LOAD: begin
            if (kind_last) state_in = jlae_pkg::ST_IDLE;
         end
         jlae_pkg::ST_UPD_RD: state_in = jlae_pkg::ST_UPD_EX;
         jlae_pkg::ST_UPD_EX: begin
            state_in = kind_last ? jlae_pkg::ST_IDLE : jlae_pkg::ST_UPD_RD;
         end
         jlae_pkg::ST_TCK_RD: state_in = jlae_pkg::ST_TCK_EX;
         jlae_pkg::ST_TCK_EX: begin
            state_in = kind_last ? jlae_pkg::ST_TCK_OUT : jlae_pkg::ST_TCK_RD;
         end
         jlae_pkg::ST_TCK_OUT: begin
            if (out_free) begin
               state_in = joint_last ? jlae_pkg::ST_IDLE : jlae_pkg::ST_TCK_RD;
            end
         end
         default: state_in = jlae_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: store writes and compare unit mode
   always_comb begin
      req_ready      = 1'b0;
      st_ctl         = '0;
      alu_ctl.tick   = 1'b0;
      alu_ctl.upper  = jlae_pkg::is_upper(kind_ff);
      alu_ctl.negate = kind_ff == jlae_pkg::KIND_VEL_LOWER;
      hld_wdata      = alu_dflt;
      stp_wdata      = '0;
      case (state_ff)
         jlae_pkg::ST_IDLE: req_ready = 1'b1;
         jlae_pkg::ST_LOAD: begin
            st_ctl.hld_we  = 1'b1;
            st_ctl.stp_we  = 1'b1;
            st_ctl.dfl_we  = kind_ff != jlae_pkg::KIND_VEL_LOWER;
            st_ctl.vld_set = 1'b1;
         end
         jlae_pkg::ST_UPD_EX: begin
            st_ctl.hld_we = mask_ff[kind_ff] && alu_tighter;
            st_ctl.stp_we = mask_ff[kind_ff] && alu_tighter;
            hld_wdata     = val_sel;
            stp_wdata     = time_ff;
         end
         jlae_pkg::ST_TCK_EX: begin
            alu_ctl.tick  = 1'b1;
            st_ctl.hld_we = !alu_recent;
         end
         default: st_ctl = '0;
      endcase
   end

   // captured value for the current kind; a load derives velocity lower
   // from the magnitude
   assign rsel = ((state_ff == jlae_pkg::ST_LOAD) && (kind_ff == jlae_pkg::KIND_VEL_LOWER))
                 ? jlae_pkg::KIND_VEL_UPPER : kind_ff;
   assign val_sel     = val_ff[rsel];
   assign alu_dfl_raw = (state_ff == jlae_pkg::ST_LOAD) ? val_sel : dfl_rdata;

   // item capture, kind and joint stepping, per-kind results
   always_comb begin
      joint_in = joint_ff;
      time_in  = time_ff;
      val_in   = val_ff;
      mask_in  = mask_ff;
      kind_in  = kind_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      res_in   = res_ff;
      if (accept) begin
         joint_in  = (req_operation == jlae_pkg::OP_TICK) ? '0 : JW'(req_joint);
         time_in   = req_time_now;
         val_in[0] = VALUE_BITS'(req_pos_upper);
         val_in[1] = VALUE_BITS'(req_pos_lower);
         val_in[2] = VALUE_BITS'(req_vel_upper);
         val_in[3] = VALUE_BITS'(req_vel_lower);
         val_in[4] = VALUE_BITS'(req_effort);
         mask_in   = req_present_mask;
         kind_in   = jlae_pkg::KIND_POS_UPPER;
         cnt_in    = '0;
         num_in    = num_req;
      end
      if ((state_ff == jlae_pkg::ST_LOAD) || (state_ff == jlae_pkg::ST_UPD_EX) ||
          (state_ff == jlae_pkg::ST_TCK_EX)) begin
         kind_in = kind_last ? jlae_pkg::KIND_POS_UPPER
                             : jlae_pkg::kind_type'(kind_ff + 3'd1);
      end
      if (state_ff == jlae_pkg::ST_TCK_EX) begin
         res_in[kind_ff] = alu_eff;
      end
      if (out_load) begin
         cnt_in   = CW'(cnt_ff + 1'b1);
         joint_in = JW'(cnt_ff + 1'b1);
      end
   end

   // result register, loaded when free or taken this cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      oj_in        = oj_ff;
      ov_in        = ov_ff;
      ostamp_in    = ostamp_ff;
      olast_in     = olast_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         oj_in        = 3'(cnt_ff);
         for (int k = 0; k < NK; k++) begin
            ov_in[k] = 32'(res_ff[k]);
         end
         ostamp_in = time_ff;
         olast_in  = joint_last;
      end
   end

   // configuration writes
   always_comb begin
      jcount_in  = jcount_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         case (csr_index)
            jlae_pkg::CSR_JOINT_COUNT:   jcount_in  = csr_wdata[3:0];
            jlae_pkg::CSR_STALE_TIMEOUT: timeout_in = csr_wdata;
            default:                     jcount_in  = jcount_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jlae_pkg::ST_IDLE;
         kind_ff      <= jlae_pkg::KIND_POS_UPPER;
         cnt_ff       <= '0;
         num_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         jcount_ff    <= jlae_pkg::JOINT_COUNT_RST;
         timeout_ff   <= jlae_pkg::STALE_TIMEOUT_RST;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         num_ff       <= num_in;
         rsp_valid_ff <= rsp_valid_in;
         jcount_ff    <= jcount_in;
         timeout_ff   <= timeout_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      joint_ff  <= joint_in;
      time_ff   <= time_in;
      val_ff    <= val_in;
      mask_ff   <= mask_in;
      res_ff    <= res_in;
      oj_ff     <= oj_in;
      ov_ff     <= ov_in;
      ostamp_ff <= ostamp_in;
      olast_ff  <= olast_in;
   end

   // limit memories
   jlae_store #(
      .MAX_JOINTS (MAX_JOINTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (st_ctl),
      .joint     (joint_ff),
      .kind      (kind_ff),
      .hld_wdata (hld_wdata),
      .stp_wdata (stp_wdata),
      .dfl_wdata (val_sel),
      .hld_rdata (hld_rdata),
      .stp_rdata (stp_rdata),
      .dfl_rdata (dfl_rdata)
   );

   // shared compare unit
   jlae_alu #(
      .VALUE_BITS (VALUE_BITS)
   ) u_alu (
      .ctl     (alu_ctl),
      .cand    (val_sel),
      .held    (hld_rdata),
      .dfl_raw (alu_dfl_raw),
      .now     (time_ff),
      .stamp   (stp_rdata),
      .timeout (timeout_ff),
      .dflt    (alu_dflt),
      .tighter (alu_tighter),
      .eff     (alu_eff),
      .recent  (alu_recent)
   );

   // result beat
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_joint     = oj_ff;
   assign rsp_out_pos_upper = ov_ff[0];
   assign rsp_out_pos_lower = ov_ff[1];
   assign rsp_out_vel_upper = ov_ff[2];
   assign rsp_out_vel_lower = ov_ff[3];
   assign rsp_out_effort    = ov_ff[4];
   assign rsp_out_stamp     = ostamp_ff;
   assign rsp_last          = olast_ff;

endmodule

/* test/joint_limit_aggregator_with_expiry_unit_tb.sv */
`timescale 1ns / 100ps
// joint_limit_aggregator_with_expiry_unit_tb: self-checking bench for the joint limit
// aggregator; a scoreboard class predicts every per-joint report of each tick.
// Depends on jlae_pkg and joint_limit_aggregator_with_expiry_unit.
module joint_limit_aggregator_with_expiry_unit_tb;
   import jlae_pkg::*;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int JOINTS = MAX_JOINTS_DEF;

   // default slots per joint
   localparam int SLOT_POS_UPPER = 0;
   localparam int SLOT_POS_LOWER = 1;
   localparam int SLOT_VEL_MAG   = 2;
   localparam int SLOT_EFFORT    = 3;

   // receiver modes
   localparam int RX_STEADY = 0;
   localparam int RX_COIN   = 1;
   localparam int RX_BURSTY = 2;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 30;
   localparam int PRINT_CAP       = 40;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 41;

   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;

   typedef struct {
      logic [1:0]         op;
      logic [2:0]         joint;
      logic [31:0]        stamp;
      logic signed [31:0] lim [NUM_KINDS];
      logic [4:0]         mask;
   } limit_item_type;

   typedef struct {
      logic [2:0]         joint;
      logic signed [31:0] lim [NUM_KINDS];
      logic [31:0]        stamp;
      logic               last;
   } limit_report_type;

   // predicts tick reports from loads, updates and register writes
   class limit_report_scoreboard;
      logic [3:0]         joint_count;
      logic [31:0]        stale_timeout;
      logic signed [31:0] dflt_limit [JOINTS][NUM_DEFAULTS];
      logic signed [31:0] held_limit [JOINTS][NUM_KINDS];
      logic [31:0]        limit_stamp [JOINTS][NUM_KINDS];
      limit_report_type   expected_reports [$];
      string              kind_label [NUM_KINDS];
      int mismatches, reports_checked, stale_kinds, tightened_kinds;
      int loads, updates, ticks, ignored;

      function new();
         joint_count   = JOINT_COUNT_RST;
         stale_timeout = STALE_TIMEOUT_RST;
         foreach (dflt_limit[j, k]) dflt_limit[j][k] = '0;
         foreach (held_limit[j, k]) held_limit[j][k] = '0;
         foreach (limit_stamp[j, k]) limit_stamp[j][k] = '0;
         kind_label = '{"pos_upper", "pos_lower", "vel_upper", "vel_lower", "effort"};
         mismatches = 0;
         reports_checked = 0;
         stale_kinds = 0;
         tightened_kinds = 0;
         loads = 0;
         updates = 0;
         ticks = 0;
         ignored = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] data);
         if (idx == CSR_JOINT_COUNT) joint_count = data[3:0];
         else if (idx == CSR_STALE_TIMEOUT) stale_timeout = data;
      endfunction

      // lower kinds tighten upward, everything else downward
      function bit bounds_from_below(int k);
         return k == KIND_POS_LOWER || k == KIND_VEL_LOWER;
      endfunction

      function logic signed [31:0] default_of(int j, int k);
         logic signed [31:0] mag;
         mag = dflt_limit[j][SLOT_VEL_MAG];
         case (k)
            KIND_POS_UPPER: return dflt_limit[j][SLOT_POS_UPPER];
            KIND_POS_LOWER: return dflt_limit[j][SLOT_POS_LOWER];
            KIND_VEL_UPPER: return mag;
            // negating the most negative magnitude saturates
            KIND_VEL_LOWER: return (mag == MOST_NEG) ? MOST_POS : -mag;
            default:        return dflt_limit[j][SLOT_EFFORT];
         endcase
      endfunction

      function void note_item(limit_item_type it);
         int n;
         bit below;
         logic [31:0] age;
         logic signed [31:0] dv;
         logic signed [31:0] eff;
         limit_report_type rep;
         case (it.op)
            OP_LOAD: begin
               loads++;
               dflt_limit[it.joint][SLOT_POS_UPPER] = it.lim[KIND_POS_UPPER];
               dflt_limit[it.joint][SLOT_POS_LOWER] = it.lim[KIND_POS_LOWER];
               dflt_limit[it.joint][SLOT_VEL_MAG]   = it.lim[KIND_VEL_UPPER];
               dflt_limit[it.joint][SLOT_EFFORT]    = it.lim[KIND_EFFORT];
               for (int k = 0; k < NUM_KINDS; k++) begin
                  held_limit[it.joint][k]  = default_of(it.joint, k);
                  limit_stamp[it.joint][k] = '0;
               end
            end
            OP_UPDATE: begin
               updates++;
               for (int k = 0; k < NUM_KINDS; k++) begin
                  if (it.mask[k]) begin
                     below = bounds_from_below(k);
                     if (below ? (it.lim[k] > held_limit[it.joint][k])
                               : (it.lim[k] < held_limit[it.joint][k])) begin
                        held_limit[it.joint][k]  = it.lim[k];
                        limit_stamp[it.joint][k] = it.stamp;
                     end
                  end
               end
            end
            OP_TICK: begin
               ticks++;
               n = (int'(joint_count) > JOINTS) ? JOINTS : int'(joint_count);
               for (int i = 0; i < n; i++) begin
                  rep.joint = 3'(i);
                  for (int k = 0; k < NUM_KINDS; k++) begin
                     dv  = default_of(i, k);
                     age = (it.stamp >= limit_stamp[i][k]) ? it.stamp - limit_stamp[i][k]
                                                           : limit_stamp[i][k] - it.stamp;
                     if (age <= stale_timeout) begin
                        below = bounds_from_below(k);
                        if (below) eff = (held_limit[i][k] > dv) ? held_limit[i][k] : dv;
                        else eff = (held_limit[i][k] < dv) ? held_limit[i][k] : dv;
                        if (eff != dv) tightened_kinds++;
                     end else begin
                        // expired: fall back to the default and forget the tightening
                        eff = dv;
                        held_limit[i][k] = dv;
                        stale_kinds++;
                     end
                     rep.lim[k] = eff;
                  end
                  rep.stamp = it.stamp;
                  rep.last  = (i == n - 1);
                  expected_reports.insert(expected_reports.size(), rep);
               end
            end
            default: ignored++;
         endcase
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task compare_field(int joint, string name, logic [31:0] got_v, logic [31:0] want_v);
         if (got_v !== want_v)
            report_mismatch($sformatf("joint %0d %s: got %h want %h", joint, name, got_v,
                                      want_v));
      endtask

      task check_report(limit_report_type got);
         limit_report_type want;
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("report beat for joint %0d with nothing pending",
                                      got.joint));
            return;
         end
         want = expected_reports.pop_front();
         reports_checked++;
         compare_field(int'(want.joint), "joint", 32'(got.joint), 32'(want.joint));
         for (int k = 0; k < NUM_KINDS; k++)
            compare_field(int'(want.joint), kind_label[k], got.lim[k], want.lim[k]);
         compare_field(int'(want.joint), "stamp", got.stamp, want.stamp);
         compare_field(int'(want.joint), "last", 32'(got.last), 32'(want.last));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [1:0]                req_operation;
   logic [2:0]                req_joint;
   logic [31:0]               req_time_now;
   logic signed [31:0]        req_pos_upper;
   logic signed [31:0]        req_pos_lower;
   logic signed [31:0]        req_vel_upper;
   logic signed [31:0]        req_vel_lower;
   logic signed [31:0]        req_effort;
   logic [4:0]                req_present_mask;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [2:0]                rsp_out_joint;
   logic signed [31:0]        rsp_out_pos_upper;
   logic signed [31:0]        rsp_out_pos_lower;
   logic signed [31:0]        rsp_out_vel_upper;
   logic signed [31:0]        rsp_out_vel_lower;
   logic signed [31:0]        rsp_out_effort;
   logic [31:0]               rsp_out_stamp;
   logic                      rsp_last;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [31:0]               csr_wdata;

   limit_report_scoreboard limits_sb;
   logic [31:0] time_origin;
   logic [31:0] time_span;
   bit          hold_request;
   int          hold_offs;
   logic [3:0]  phase_joints [PHASES];
   logic [31:0] phase_timeout [PHASES];

   joint_limit_aggregator_with_expiry_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_joint         (req_joint),
      .req_time_now      (req_time_now),
      .req_pos_upper     (req_pos_upper),
      .req_pos_lower     (req_pos_lower),
      .req_vel_upper     (req_vel_upper),
      .req_vel_lower     (req_vel_lower),
      .req_effort        (req_effort),
      .req_present_mask  (req_present_mask),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_joint     (rsp_out_joint),
      .rsp_out_pos_upper (rsp_out_pos_upper),
      .rsp_out_pos_lower (rsp_out_pos_lower),
      .rsp_out_vel_upper (rsp_out_vel_upper),
      .rsp_out_vel_lower (rsp_out_vel_lower),
      .rsp_out_effort    (rsp_out_effort),
      .rsp_out_stamp     (rsp_out_stamp),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("joint_limit_aggregator_with_expiry_unit regression: fail");
      $finish;
   end

   // result beats are checked at the rising edge
   always @(posedge clock) begin : rsp_monitor
      limit_report_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got.joint                = rsp_out_joint;
         got.lim[KIND_POS_UPPER] = rsp_out_pos_upper;
         got.lim[KIND_POS_LOWER] = rsp_out_pos_lower;
         got.lim[KIND_VEL_UPPER] = rsp_out_vel_upper;
         got.lim[KIND_VEL_LOWER] = rsp_out_vel_lower;
         got.lim[KIND_EFFORT]    = rsp_out_effort;
         got.stamp                = rsp_out_stamp;
         got.last                 = rsp_last;
         limits_sb.check_report(got);
      end
   end

   // receiver: steady, coin-flip and bursty stretches, plus the long hold-off
   initial begin : rsp_side
      int hold_left;
      int stall_left;
      int mode;
      int mode_left;
      rsp_ready  = 1'b0;
      hold_left  = 0;
      stall_left = 0;
      mode       = RX_STEADY;
      mode_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
            hold_offs++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(RX_STEADY, RX_BURSTY);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               RX_STEADY: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_ready <= 1'b0;
                  end else begin
                     rsp_ready <= 1'b1;
                     if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
                  end
               end
            endcase
         end
      end
   end

   // one beat on the request channel; returns at the next falling edge
   task automatic send_item(limit_item_type it);
      req_valid        <= 1'b1;
      req_operation    <= it.op;
      req_joint        <= it.joint;
      req_time_now     <= it.stamp;
      req_pos_upper    <= it.lim[KIND_POS_UPPER];
      req_pos_lower    <= it.lim[KIND_POS_LOWER];
      req_vel_upper    <= it.lim[KIND_VEL_UPPER];
      req_vel_lower    <= it.lim[KIND_VEL_LOWER];
      req_effort       <= it.lim[KIND_EFFORT];
      req_present_mask <= it.mask;
      do @(posedge clock); while (req_ready !== 1'b1);
      limits_sb.note_item(it);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // wait for every pending report, then let a trailing load or update finish
   task automatic settle();
      req_valid <= 1'b0;
      while (limits_sb.expected_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      limits_sb.write_register(idx, data);
   endtask

   function automatic limit_item_type make_item(logic [1:0] op, logic [2:0] joint,
         logic [31:0] stamp, logic signed [31:0] pu, logic signed [31:0] pl,
         logic signed [31:0] vu, logic signed [31:0] vl, logic signed [31:0] ef,
         logic [4:0] mask);
      limit_item_type it;
      it.op                  = op;
      it.joint               = joint;
      it.stamp               = stamp;
      it.lim[KIND_POS_UPPER] = pu;
      it.lim[KIND_POS_LOWER] = pl;
      it.lim[KIND_VEL_UPPER] = vu;
      it.lim[KIND_VEL_LOWER] = vl;
      it.lim[KIND_EFFORT]    = ef;
      it.mask                = mask;
      return it;
   endfunction

   // mostly near an anchor, sometimes the extremes or anything at all
   function automatic logic signed [31:0] spread_value(logic signed [31:0] anchor, int reach);
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return MOST_NEG;
         2:       return MOST_POS;
         default: return anchor + $signed($urandom_range(0, 2 * reach)) - reach;
      endcase
   endfunction

   // times cluster in a window around the phase origin so both fresh and stale show up
   function automatic logic [31:0] pick_time();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return time_origin + $urandom_range(0, time_span);
   endfunction

   function automatic limit_item_type random_item();
      limit_item_type it;
      int pick;
      pick     = $urandom_range(0, 99);
      it.joint = 3'($urandom_range(0, JOINTS - 1));
      it.mask  = ($urandom_range(0, 2) == 0) ? 5'h1F : 5'($urandom_range(0, 31));
      it.stamp = pick_time();
      for (int k = 0; k < NUM_KINDS; k++) it.lim[k] = $urandom;
      if (pick < 4) begin
         it.op = OP_IGNORED;
      end else if (pick < 12) begin
         it.op = OP_LOAD;
         for (int k = 0; k < NUM_KINDS; k++) it.lim[k] = spread_value('0, 1 << 20);
      end else if (pick < 40) begin
         it.op = OP_TICK;
      end else begin
         it.op = OP_UPDATE;
         for (int k = 0; k < NUM_KINDS; k++)
            it.lim[k] = spread_value($urandom_range(0, 1) ? limits_sb.held_limit[it.joint][k]
                                                         : limits_sb.default_of(it.joint, k),
                                     2048);
      end
      return it;
   endfunction

   task automatic run_directed();
      // every joint gets defaults first, so nothing reads an unwritten entry
      send_item(make_item(OP_LOAD, 3'd0, '0, MOST_POS, MOST_NEG, MOST_POS, $urandom, MOST_POS,
                          5'h00));
      // most negative velocity magnitude: the lower velocity default saturates
      send_item(make_item(OP_LOAD, 3'd1, $urandom, 32'sh0010_0000, -32'sh0010_0000, MOST_NEG,
                          $urandom, 32'sh0005_0000, 5'h1F));
      send_item(make_item(OP_LOAD, 3'd2, $urandom, '0, '0, '0, '0, '0, 5'h0A));
      for (int j = 3; j < JOINTS; j++)
         send_item(make_item(OP_LOAD, 3'(j), $urandom, spread_value(32'sh0020_0000, 1 << 20),
                             spread_value(-32'sh0020_0000, 1 << 20),
                             spread_value(32'sh0004_0000, 1 << 16), $urandom,
                             spread_value(32'sh0008_0000, 1 << 18), 5'($urandom_range(0, 31))));
      // unknown operation is dropped
      send_item(make_item(OP_IGNORED, 3'd7, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, 5'h1F));
      // tighten all kinds of joint 0, then report at, just past, and after expiry
      send_item(make_item(OP_UPDATE, 3'd0, 32'd1000, 32'sd100, -32'sd100, 32'sd50, -32'sd50,
                          32'sd70, 5'h1F));
      send_item(make_item(OP_TICK, 3'd0, 32'd101000, $urandom, $urandom, $urandom, $urandom,
                          $urandom, 5'h1F));
      send_item(make_item(OP_TICK, 3'd0, 32'd101001, $urandom, $urandom, $urandom, $urandom,
                          $urandom, 5'h00));
      send_item(make_item(OP_TICK, 3'd0, 32'd1000, '0, '0, '0, '0, '0, 5'h00));
      send_item(make_item(OP_UPDATE, 3'd0, 32'hFFFF_FFFF, MOST_NEG, '0, '0, '0, MOST_NEG,
                          5'h11));
      settle();
      write_csr(CSR_JOINT_COUNT, 32'd8);
      write_csr(CSR_STALE_TIMEOUT, 32'd0);
      // saturated lower velocity default cannot be tightened further
      send_item(make_item(OP_UPDATE, 3'd1, 32'hFFFF_FFFF, '0, -32'sd100, '0, MOST_POS, '0,
                          5'h0A));
      send_item(make_item(OP_UPDATE, 3'd3, 32'd5, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS,
                          MOST_NEG, 5'h00));
      send_item(make_item(OP_UPDATE, 3'd2, 32'd0, 32'sd1, -32'sd1, -32'sd1, 32'sd1, '0, 5'h1F));
      send_item(make_item(OP_TICK, 3'd5, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, 5'h00));
      send_item(make_item(OP_TICK, 3'd2, 32'd0, '0, '0, '0, '0, '0, 5'h00));
      settle();
      // no joints in use: a tick reports nothing
      write_csr(CSR_JOINT_COUNT, 32'd0);
      send_item(make_item(OP_TICK, 3'd0, $urandom, '0, '0, '0, '0, '0, 5'h00));
      settle();
      // count above the joint table is clamped
      write_csr(CSR_JOINT_COUNT, 32'hFFFF_FFFF);
      send_item(make_item(OP_TICK, 3'd4, $urandom, '0, '0, '0, '0, '0, 5'h00));
      settle();
      write_csr(CSR_STALE_TIMEOUT, 32'hFFFF_FFFF);
      send_item(make_item(OP_UPDATE, 3'd5, 32'h8000_0000, spread_value('0, 1 << 20),
                          spread_value('0, 1 << 20), spread_value('0, 1 << 16),
                          spread_value('0, 1 << 16), spread_value('0, 1 << 18), 5'h1F));
      send_item(make_item(OP_TICK, 3'd6, 32'd0, '0, '0, '0, '0, '0, 5'h00));
      send_item(make_item(OP_TICK, 3'd7, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, 5'h00));
   endtask

   // bursts of beats separated by random gaps, or back to back when steady
   task automatic run_random_phase(int count, bit steady);
      limit_item_type it;
      int sent;
      int burst_left;
      sent       = 0;
      burst_left = 0;
      while (sent < count) begin
         it = random_item();
         if (burst_left == 0) begin
            pause_sender(steady ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 10);
         end
         send_item(it);
         burst_left--;
         if (it.op != OP_IGNORED) sent++;
      end
   endtask

   initial begin
      limits_sb        = new();
      hold_request     = 1'b0;
      hold_offs        = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_LOAD;
      req_joint        = '0;
      req_time_now     = '0;
      req_pos_upper    = '0;
      req_pos_lower    = '0;
      req_vel_upper    = '0;
      req_vel_lower    = '0;
      req_effort       = '0;
      req_present_mask = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_JOINT_COUNT;
      csr_wdata        = '0;
      time_origin      = '0;
      time_span        = '0;
      phase_joints     = '{4'd3, 4'd8, 4'd15, 4'd1, 4'd0, 4'd5, 4'd8, 4'd2};
      phase_timeout    = '{32'd1000, 32'd0, STALE_TIMEOUT_RST, 32'hFFFF_FFFF, 32'd250,
                           32'd0, 32'd20, 32'd5000};
      phase_timeout[5] = $urandom;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_csr(CSR_JOINT_COUNT, ($urandom & 32'hFFFF_FFF0) | phase_joints[p]);
         write_csr(CSR_STALE_TIMEOUT, phase_timeout[p]);
         time_origin = $urandom;
         time_span   = (limits_sb.stale_timeout > 32'h3FFF_FFFF) ? 32'hFFFF_FFFF
                                                                 : limits_sb.stale_timeout * 2 + 8;
         // long receiver hold-off while ticks keep coming: the block backs up
         if (p == 1) hold_request = 1'b1;
         run_random_phase(ITEMS_PER_PHASE, p == 1 || p == 4);
      end
      settle();

      $display("run covered %0d loads, %0d updates, %0d ticks, %0d dropped beats, %0d reports",
               limits_sb.loads, limits_sb.updates, limits_sb.ticks, limits_sb.ignored,
               limits_sb.reports_checked);
      $display("expired kinds %0d, tightened kinds reported %0d, receiver hold-offs %0d",
               limits_sb.stale_kinds, limits_sb.tightened_kinds, hold_offs);
      if (limits_sb.mismatches == 0) begin
         $display("joint_limit_aggregator_with_expiry_unit regression: pass");
      end else begin
         $display("joint_limit_aggregator_with_expiry_unit regression: fail");
      end
      $finish;
   end

endmodule
